// File: design/fdcp_pkg.sv
// ----------------------------------------------------------------------------
// Framed display command parser package
// Shared phase type, command and result codes, frame limits and the result
// beat structure.
// ----------------------------------------------------------------------------
`default_nettype none

package fdcp_pkg;

    localparam logic [7:0]  StartByte       = 8'h02;
    localparam int          NumParams       = 10;
    localparam int          MaxText         = 255;
    localparam logic [31:0] MinFillLength   = 32'd10;
    localparam logic [31:0] MinImageLength  = 32'd8;
    localparam logic [31:0] MinStringLength = 32'd8;
    localparam logic [31:0] MaxStringLength = 32'(7 + MaxText);
    localparam logic [31:0] StringHeaderPos = 32'd7;
    localparam logic [31:0] WindowPos       = 32'd8;
    localparam logic [7:0]  TextOffset      = 8'd7;

    typedef enum logic [2:0] {
        PhStart,
        PhCode,
        PhLength,
        PhPayload,
        PhEnd
    } phase_t;

    localparam logic [2:0] CmdFill   = 3'd0;
    localparam logic [2:0] CmdImage  = 3'd1;
    localparam logic [2:0] CmdString = 3'd2;
    localparam logic [2:0] CmdClear  = 3'd3;
    localparam logic [2:0] CmdRaw    = 3'd4;
    localparam logic [7:0] MaxCmd    = 8'd4;

    localparam logic [3:0] KindFill      = 4'd0;
    localparam logic [3:0] KindWindow    = 4'd1;
    localparam logic [3:0] KindPixel     = 4'd2;
    localparam logic [3:0] KindImageDone = 4'd3;
    localparam logic [3:0] KindRawCmd    = 4'd4;
    localparam logic [3:0] KindRawData   = 4'd5;
    localparam logic [3:0] KindStrHeader = 4'd6;
    localparam logic [3:0] KindTextChar  = 4'd7;
    localparam logic [3:0] KindClear     = 4'd8;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] x_start;
        logic [15:0] y_start;
        logic [15:0] x_end;
        logic [15:0] y_end;
        logic [15:0] colour;
        logic [7:0]  text_scale;
        logic [7:0]  text_length;
        logic [7:0]  byte_value;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } step_out_t;

endpackage

`default_nettype wire

// File: design/fdcp_parser.sv
// ----------------------------------------------------------------------------
// Frame parser
// Holds the frame state and turns one received byte into zero, one or two
// result beats in the same cycle; the state advances when the byte is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fdcp_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic [7:0]         rx_byte,
    output fdcp_pkg::step_out_t     results
);

    fdcp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  command_code_reg, command_code_next;
    logic [1:0]  length_seen_reg, length_seen_next;
    logic [23:0] length_high_reg, length_high_next;
    logic [31:0] payload_length_reg, payload_length_next;
    logic [31:0] payload_count_reg, payload_count_next;
    logic        raw_after_first_reg, raw_after_first_next;
    logic [7:0]  params_reg [fdcp_pkg::NumParams];
    logic [7:0]  params_next [fdcp_pkg::NumParams];
    logic [31:0] length_word;
    logic [31:0] count_inc;
    logic [15:0] px, py, ph, pw;

    always_comb
    begin
        phase_next           = phase_reg;
        command_code_next    = command_code_reg;
        length_seen_next     = length_seen_reg;
        length_high_next     = length_high_reg;
        payload_length_next  = payload_length_reg;
        payload_count_next   = payload_count_reg;
        raw_after_first_next = raw_after_first_reg;
        results              = '0;
        length_word          = {length_high_reg, rx_byte};
        count_inc            = payload_count_reg + 32'd1;

        for (int i = 0; i < fdcp_pkg::NumParams; i++)
        begin
            params_next[i] = (count_inc == 32'(i + 1)) ? rx_byte : params_reg[i];
        end

        px = {params_next[0], params_next[1]};
        py = {params_next[2], params_next[3]};
        ph = {params_next[4], params_next[5]};
        pw = {params_next[6], params_next[7]};

        unique case (phase_reg)
            fdcp_pkg::PhStart:
            begin
                phase_next = (rx_byte == fdcp_pkg::StartByte) ?
                             fdcp_pkg::PhCode : fdcp_pkg::PhStart;
            end
            fdcp_pkg::PhCode:
            begin
                if (rx_byte <= fdcp_pkg::MaxCmd)
                begin
                    command_code_next = rx_byte[2:0];
                    length_seen_next  = 2'd0;
                    length_high_next  = '0;
                    phase_next        = fdcp_pkg::PhLength;
                end
                else
                begin
                    phase_next = fdcp_pkg::PhStart;
                end
            end
            fdcp_pkg::PhLength:
            begin
                if (length_seen_reg != 2'd3)
                begin
                    length_high_next = {length_high_reg[15:0], rx_byte};
                    length_seen_next = length_seen_reg + 2'd1;
                end
                else
                begin
                    length_seen_next    = 2'd0;
                    length_high_next    = '0;
                    payload_length_next = length_word;
                    payload_count_next  = '0;
                    if (length_word == 32'd0)
                    begin
                        if (command_code_reg == fdcp_pkg::CmdClear)
                        begin
                            results.count      = 2'd1;
                            results.first.kind = fdcp_pkg::KindClear;
                            phase_next         = fdcp_pkg::PhEnd;
                        end
                        else if (command_code_reg == fdcp_pkg::CmdRaw)
                        begin
                            phase_next = fdcp_pkg::PhEnd;
                        end
                        else
                        begin
                            phase_next = fdcp_pkg::PhStart;
                        end
                    end
                    else if ((command_code_reg == fdcp_pkg::CmdFill &&
                              length_word < fdcp_pkg::MinFillLength) ||
                             (command_code_reg == fdcp_pkg::CmdImage &&
                              length_word < fdcp_pkg::MinImageLength) ||
                             (command_code_reg == fdcp_pkg::CmdString &&
                              length_word < fdcp_pkg::MinStringLength) ||
                             (command_code_reg == fdcp_pkg::CmdString &&
                              length_word > fdcp_pkg::MaxStringLength) ||
                             command_code_reg > fdcp_pkg::CmdRaw)
                    begin
                        phase_next = fdcp_pkg::PhStart;
                    end
                    else
                    begin
                        phase_next = fdcp_pkg::PhPayload;
                    end
                end
            end
            fdcp_pkg::PhPayload:
            begin
                payload_count_next = count_inc;
                unique case (command_code_reg)
                    fdcp_pkg::CmdFill:
                    begin
                        if (count_inc == payload_length_reg)
                        begin
                            results.count         = 2'd1;
                            results.first.kind    = fdcp_pkg::KindFill;
                            results.first.x_start = px;
                            results.first.y_start = py;
                            results.first.x_end   = ph;
                            results.first.y_end   = pw;
                            results.first.colour  = {params_next[8], params_next[9]};
                            phase_next            = fdcp_pkg::PhEnd;
                        end
                    end
                    fdcp_pkg::CmdImage:
                    begin
                        if (count_inc == fdcp_pkg::WindowPos)
                        begin
                            results.count         = 2'd1;
                            results.first.kind    = fdcp_pkg::KindWindow;
                            results.first.x_start = px;
                            results.first.y_start = py;
                            results.first.x_end   = px + pw - 16'd1;
                            results.first.y_end   = py + ph - 16'd1;
                        end
                        else if (count_inc > fdcp_pkg::WindowPos)
                        begin
                            results.count            = 2'd1;
                            results.first.kind       = fdcp_pkg::KindPixel;
                            results.first.byte_value = rx_byte;
                        end
                        if (count_inc == payload_length_reg)
                        begin
                            results.count       = 2'd2;
                            results.second.kind = fdcp_pkg::KindImageDone;
                            phase_next          = fdcp_pkg::PhEnd;
                        end
                    end
                    fdcp_pkg::CmdString:
                    begin
                        if (count_inc == fdcp_pkg::StringHeaderPos)
                        begin
                            results.count             = 2'd1;
                            results.first.kind        = fdcp_pkg::KindStrHeader;
                            results.first.x_start     = px;
                            results.first.y_start     = py;
                            results.first.colour      = {params_next[5], params_next[6]};
                            results.first.text_scale  = params_next[4];
                            results.first.text_length =
                                payload_length_reg[7:0] - fdcp_pkg::TextOffset;
                        end
                        else if (count_inc > fdcp_pkg::StringHeaderPos)
                        begin
                            results.count            = 2'd1;
                            results.first.kind       = fdcp_pkg::KindTextChar;
                            results.first.byte_value = rx_byte;
                        end
                        if (count_inc == payload_length_reg)
                        begin
                            phase_next = fdcp_pkg::PhEnd;
                        end
                    end
                    fdcp_pkg::CmdClear:
                    begin
                        results.count      = 2'd1;
                        results.first.kind = fdcp_pkg::KindClear;
                        phase_next         = fdcp_pkg::PhEnd;
                    end
                    fdcp_pkg::CmdRaw:
                    begin
                        results.count            = 2'd1;
                        results.first.kind       = raw_after_first_reg ?
                                                   fdcp_pkg::KindRawData :
                                                   fdcp_pkg::KindRawCmd;
                        results.first.byte_value = rx_byte;
                        raw_after_first_next     = 1'b1;
                        if (count_inc == payload_length_reg)
                        begin
                            raw_after_first_next = 1'b0;
                            phase_next           = fdcp_pkg::PhEnd;
                        end
                    end
                    default:
                    begin
                        phase_next = fdcp_pkg::PhStart;
                    end
                endcase
            end
            fdcp_pkg::PhEnd:
            begin
                phase_next = fdcp_pkg::PhStart;
            end
            default:
            begin
                phase_next = (rx_byte == fdcp_pkg::StartByte) ?
                             fdcp_pkg::PhCode : fdcp_pkg::PhStart;
            end
        endcase

        if (results.count == 2'd1)
        begin
            results.first.last = 1'b1;
        end
        else if (results.count == 2'd2)
        begin
            results.second.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= fdcp_pkg::PhStart;
            command_code_reg    <= '0;
            length_seen_reg     <= '0;
            length_high_reg     <= '0;
            payload_length_reg  <= '0;
            payload_count_reg   <= '0;
            raw_after_first_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg           <= phase_next;
            command_code_reg    <= command_code_next;
            length_seen_reg     <= length_seen_next;
            length_high_reg     <= length_high_next;
            payload_length_reg  <= payload_length_next;
            payload_count_reg   <= payload_count_next;
            raw_after_first_reg <= raw_after_first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && phase_reg == fdcp_pkg::PhPayload)
        begin
            params_reg <= params_next;
        end
    end

endmodule

`default_nettype wire

// File: design/framed_display_command_parser.sv
// ----------------------------------------------------------------------------
// Framed display command parser
// Parses start-byte framed, length-prefixed display frames and emits one
// display command beat at a time through a three-entry result queue.
// ----------------------------------------------------------------------------
// Result beats of a taken byte are registered into the queue behind beats already held.
// Throughput: one byte per cycle while in_stall is low; a two-beat byte raises in_stall.
// The queue takes a byte only while it holds at most one beat.
// Reset clears the parse state and empties the queue.
`default_nettype none

module framed_display_command_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       kind,
    output logic [15:0]      x_start,
    output logic [15:0]      y_start,
    output logic [15:0]      x_end,
    output logic [15:0]      y_end,
    output logic [15:0]      colour,
    output logic [7:0]       text_scale,
    output logic [7:0]       text_length,
    output logic [7:0]       byte_value,
    output logic             last
);

    fdcp_pkg::step_out_t results;
    fdcp_pkg::result_t   queue_reg [3];
    fdcp_pkg::result_t   queue_next [3];
    logic [1:0]          count_reg, count_next;
    logic [1:0]          fill;
    logic                accept;
    logic                pop;

    assign in_stall  = (count_reg > 2'd1);
    assign accept    = in_valid && !in_stall;
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && !out_stall;

    fdcp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (accept),
        .rx_byte (rx_byte),
        .results (results)
    );

    always_comb
    begin
        queue_next = queue_reg;
        fill       = count_reg;
        if (pop)
        begin
            queue_next[0] = queue_reg[1];
            queue_next[1] = queue_reg[2];
            fill          = count_reg - 2'd1;
        end
        count_next = fill;
        if (accept)
        begin
            if (results.count != 2'd0)
            begin
                queue_next[fill] = results.first;
            end
            if (results.count == 2'd2)
            begin
                queue_next[fill + 2'd1] = results.second;
            end
            count_next = fill + results.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        queue_reg <= queue_next;
    end

    assign kind        = queue_reg[0].kind;
    assign x_start     = queue_reg[0].x_start;
    assign y_start     = queue_reg[0].y_start;
    assign x_end       = queue_reg[0].x_end;
    assign y_end       = queue_reg[0].y_end;
    assign colour      = queue_reg[0].colour;
    assign text_scale  = queue_reg[0].text_scale;
    assign text_length = queue_reg[0].text_length;
    assign byte_value  = queue_reg[0].byte_value;
    assign last        = queue_reg[0].last;

endmodule

`default_nettype wire
